// ===== sv/bais_pkg.sv =====
`default_nettype none

package bais_pkg;

	// Fixed-point scale of the shrink ratio: 1.0 is 1 << SCALE_LOG.
	localparam int unsigned SCALE_LOG = 10;
	localparam int unsigned SCALE_ONE = 1 << SCALE_LOG;
	localparam int unsigned RATIO_W = SCALE_LOG + 1;

	localparam int unsigned CFG_W = 12;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned SUM_W = 32;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam int unsigned IN_TDATA_W = 3 * PIX_W;
	localparam int unsigned OUT_TDATA_W = 48;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SRC_W = 2'd0;
	localparam reg_idx_t REG_SRC_H = 2'd1;
	localparam reg_idx_t REG_DSP_W = 2'd2;
	localparam reg_idx_t REG_DSP_H = 2'd3;

endpackage

`default_nettype wire

// ===== sv/bais_ram.sv =====
`default_nettype none

module bais_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 2048
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/bais_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. done pulses once the last quotient bit is in.
module bais_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 24
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/box_average_image_shrinker.sv =====
`default_nettype none

// Box-average image shrinker.
// Source RGB pixels arrive in raster order on the s_axis channel, one per
// transaction. At the first pixel of each frame the block latches the frame
// size from the APB registers and derives the shrink ratio. With a ratio of
// one or more, pixels pass through unchanged with their own coordinates.
// Otherwise each output cell's mean leaves on m_axis when its last source
// pixel arrives; tlast marks the final result caused by one input pixel.
// Items are handled one at a time. A pixel that closes a cell waits while the
// mean goes through a serial divider per channel, and the first pixel of a
// frame also waits for the ratio and, when the frame shrinks, its reciprocal.
// The column sums live in one synchronous RAM of MAX_WIDTH entries, read in
// one cycle and written back in the next. After reset the block clears that
// RAM entry by entry while s_axis_tready stays low. When the receiver
// stalls, no new pixel is taken until every result of the current one left.
module box_average_image_shrinker #(
	parameter int unsigned MAX_WIDTH = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Source pixel channel. tdata: red [7:0], green [15:8], blue [23:16].
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [bais_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Result channel. tdata: avg_red [7:0], avg_green [15:8], avg_blue [23:16],
	// out_col [34:24], out_row [45:35], zero [47:46].
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [bais_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast,
	// Register port.
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [bais_pkg::ADDR_W-1:0]         paddr,
	input  wire  [bais_pkg::DATA_W-1:0]         pwdata,
	output logic [bais_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned YAW = $clog2(MAX_HEIGHT);
	localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned RW = bais_pkg::RATIO_W;
	localparam int unsigned EW0 = (XW > YW) ? XW : YW;
	localparam int unsigned EW = ((EW0 > RW) ? EW0 : RW) + 1;
	localparam int unsigned DEN_W = XW + YW;
	localparam int unsigned SW = bais_pkg::SUM_W;
	localparam int unsigned PW = bais_pkg::PIX_W;
	localparam int unsigned CW = bais_pkg::CFG_W;
	localparam int unsigned OCW = bais_pkg::COORD_W;

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_DIVR = 9'b000000100,
		ST_DIVS = 9'b000001000,
		ST_PIX  = 9'b000010000,
		ST_RD   = 9'b000100000,
		ST_AREA = 9'b001000000,
		ST_DIVM = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [SW-1:0] red;
		logic [SW-1:0] green;
		logic [SW-1:0] blue;
	} sums_t;

	// The FIN step of a pixel is folded into the transition back to idle.
	logic          fin;

	state_t        st_q;
	logic [CW-1:0] src_w_q, src_h_q, dsp_w_q, dsp_h_q;
	logic [PW-1:0] red_q, grn_q, blu_q;
	logic [AW-1:0] sx_q;
	logic [YAW-1:0] sy_q;
	logic [XW-1:0] fw_q;
	logic [YW-1:0] fh_q;
	logic [RW-1:0] ratio_q, sq_q, sr_q;
	logic [XW-1:0] dst_w_q;
	logic [YW-1:0] dst_h_q;
	logic [YW-1:0] band_row_q;
	logic [XW-1:0] cell_col_q;
	logic [EW-1:0] from_q, to_q, y0_q, bb_q;
	logic [RW-1:0] to_r_q, bb_r_q;
	sums_t         sums_q;
	logic [DEN_W-1:0] area_q;
	logic [OCW-1:0] oc_q;
	logic [XW-1:0] ecol_q;
	logic          empty_q, rowend_q;
	logic [PW-1:0] ored_q, ogrn_q, oblu_q;
	logic [OCW-1:0] ocol_q, orow_q;
	logic          olast_q, more_q;
	logic [AW-1:0] clr_q;

	// Configuration port.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			bais_pkg::REG_SRC_W: prdata = bais_pkg::DATA_W'(src_w_q);
			bais_pkg::REG_SRC_H: prdata = bais_pkg::DATA_W'(src_h_q);
			bais_pkg::REG_DSP_W: prdata = bais_pkg::DATA_W'(dsp_w_q);
			bais_pkg::REG_DSP_H: prdata = bais_pkg::DATA_W'(dsp_h_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= CW'(1);
			src_h_q <= CW'(1);
			dsp_w_q <= CW'(1);
			dsp_h_q <= CW'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bais_pkg::REG_SRC_W: src_w_q <= pwdata[CW-1:0];
				bais_pkg::REG_SRC_H: src_h_q <= pwdata[CW-1:0];
				bais_pkg::REG_DSP_W: dsp_w_q <= pwdata[CW-1:0];
				bais_pkg::REG_DSP_H: dsp_h_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// Frame size with zero taken as one and oversize clamped to the maximum.
	logic [XW-1:0] fw_fit;
	logic [YW-1:0] fh_fit;
	always_comb begin
		if (src_w_q == '0) begin
			fw_fit = XW'(1);
		end else if (32'(src_w_q) > MAX_WIDTH) begin
			fw_fit = XW'(MAX_WIDTH);
		end else begin
			fw_fit = XW'(src_w_q);
		end
		if (src_h_q == '0) begin
			fh_fit = YW'(1);
		end else if (32'(src_h_q) > MAX_HEIGHT) begin
			fh_fit = YW'(MAX_HEIGHT);
		end else begin
			fh_fit = YW'(src_h_q);
		end
	end

	// Dividers: frame ratios and reciprocal at frame start, cell means otherwise.
	logic             div_start_r, div_start_b;
	logic [SW-1:0]    num_r, num_g, num_b;
	logic [DEN_W-1:0] den_r, den_g, den_b, area_fix;
	logic             done_r, done_g, done_b;
	logic [SW-1:0]    quo_r, quo_g, quo_b;
	logic [DEN_W-1:0] rem_r, rem_g, rem_b;
	logic             setup;

	assign setup = (st_q == ST_IDLE) || (st_q == ST_DIVR);
	assign area_fix = (area_q == '0) ? DEN_W'(1) : area_q;

	logic [SW-1:0] qmin;
	logic [RW-1:0] ratio_n;
	always_comb begin
		qmin = (quo_r < quo_g) ? quo_r : quo_g;
		ratio_n = (qmin > SW'(bais_pkg::SCALE_ONE)) ? RW'(bais_pkg::SCALE_ONE) : RW'(qmin);
	end

	logic ratio_mid;
	assign ratio_mid = (ratio_n != '0) && (ratio_n < RW'(bais_pkg::SCALE_ONE));

	always_comb begin
		div_start_r = ((st_q == ST_IDLE) && s_axis_tvalid && sx_q == '0 && sy_q == '0)
			|| (st_q == ST_AREA);
		div_start_b = ((st_q == ST_DIVR) && done_r && ratio_mid) || (st_q == ST_AREA);
		num_r = setup ? SW'({dsp_w_q, bais_pkg::SCALE_LOG'(0)}) : sums_q.red;
		den_r = setup ? DEN_W'(fw_fit) : area_fix;
		num_g = setup ? SW'({dsp_h_q, bais_pkg::SCALE_LOG'(0)}) : sums_q.green;
		den_g = setup ? DEN_W'(fh_fit) : area_fix;
		num_b = setup ? SW'(bais_pkg::SCALE_ONE) : sums_q.blue;
		den_b = setup ? DEN_W'(ratio_n) : area_fix;
	end

	bais_div #(.NW(SW), .DW(DEN_W)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start_r), .num(num_r), .den(den_r),
		.done(done_r), .quo(quo_r), .rem(rem_r)
	);
	bais_div #(.NW(SW), .DW(DEN_W)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start_r), .num(num_g), .den(den_g),
		.done(done_g), .quo(quo_g), .rem(rem_g)
	);
	bais_div #(.NW(SW), .DW(DEN_W)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start_b), .num(num_b), .den(den_b),
		.done(done_b), .quo(quo_b), .rem(rem_b)
	);

	// Column sums memory: read at PIX, modify and write back at RD.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	sums_t         mem_wdata, mem_rdata;

	bais_ram #(.WIDTH(3 * SW), .DEPTH(MAX_WIDTH)) u_sums (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(cell_col_q[AW-1:0]), .rdata(mem_rdata)
	);

	// Next cell boundary: add 1024/ratio with a carry from the remainder,
	// saturating at the frame edge.
	logic [RW-1:0] col_rs, col_rn, row_rs, row_rn;
	logic [EW-1:0] col_qs, col_qn, row_qs, row_qn, col_init, row_init;
	logic          col_c, row_c;
	always_comb begin
		col_rs = to_r_q + sr_q;
		col_c  = col_rs >= ratio_q;
		col_rn = col_c ? col_rs - ratio_q : col_rs;
		col_qs = to_q + EW'(sq_q) + EW'(col_c);
		col_qn = (col_qs > EW'(fw_q)) ? EW'(fw_q) : col_qs;
		row_rs = bb_r_q + sr_q;
		row_c  = row_rs >= ratio_q;
		row_rn = row_c ? row_rs - ratio_q : row_rs;
		row_qs = bb_q + EW'(sq_q) + EW'(row_c);
		row_qn = (row_qs > EW'(fh_q)) ? EW'(fh_q) : row_qs;
		col_init = (EW'(sq_q) > EW'(fw_q)) ? EW'(fw_q) : EW'(sq_q);
		row_init = (EW'(sq_q) > EW'(fh_q)) ? EW'(fh_q) : EW'(sq_q);
	end

	// Output frame size; the products need the full width before the shift.
	logic [RW+YW-1:0] dst_h_prod;
	logic [RW+XW-1:0] dst_w_prod;
	assign dst_h_prod = (RW+YW)'(ratio_q) * (RW+YW)'(fh_q);
	assign dst_w_prod = (RW+XW)'(ratio_q) * (RW+XW)'(fw_q);

	// Per-pixel decisions in the RD cycle.
	logic          in_band, hit, band_last, emit, row_end, empty;
	logic [XW-1:0] c_next;
	sums_t         sums_new;
	always_comb begin
		in_band   = (cell_col_q < dst_w_q) && (32'(cell_col_q) < MAX_WIDTH);
		hit       = in_band && ((EW'(sx_q) + 1'b1) >= to_q);
		band_last = (EW'(sy_q) + 1'b1) == bb_q;
		emit      = hit && band_last;
		c_next    = hit ? cell_col_q + 1'b1 : cell_col_q;
		row_end   = ((EW'(sx_q) + 1'b1) >= EW'(fw_q)) && band_last;
		empty     = row_end && (c_next < dst_w_q);
		sums_new.red   = mem_rdata.red + SW'(red_q);
		sums_new.green = mem_rdata.green + SW'(grn_q);
		sums_new.blue  = mem_rdata.blue + SW'(blu_q);
		mem_we    = (st_q == ST_CLR) || ((st_q == ST_RD) && in_band);
		mem_waddr = (st_q == ST_CLR) ? clr_q : cell_col_q[AW-1:0];
		mem_wdata = ((st_q == ST_CLR) || emit) ? '0 : sums_new;
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {2'b00, orow_q, ocol_q, oblu_q, ogrn_q, ored_q};

	always_comb begin
		fin = 1'b0;
		unique case (st_q)
			ST_PIX:  fin = (ratio_q < RW'(bais_pkg::SCALE_ONE))
				&& ((ratio_q == '0) || (band_row_q >= dst_h_q));
			ST_RD:   fin = !emit && !empty;
			ST_OUT:  fin = m_axis_tready && !more_q;
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			fw_q <= '0;
			fh_q <= '0;
			ratio_q <= '0;
			band_row_q <= '0;
			cell_col_q <= '0;
			rowend_q <= 1'b0;
			empty_q <= 1'b0;
			more_q <= 1'b0;
			olast_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_WIDTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						red_q <= s_axis_tdata[PW-1:0];
						grn_q <= s_axis_tdata[2*PW-1:PW];
						blu_q <= s_axis_tdata[3*PW-1:2*PW];
						if (sx_q == '0 && sy_q == '0) begin
							fw_q <= fw_fit;
							fh_q <= fh_fit;
							st_q <= ST_DIVR;
						end else begin
							st_q <= ST_PIX;
						end
					end
				end
				ST_DIVR: begin
					if (done_r) begin
						ratio_q <= ratio_n;
						band_row_q <= '0;
						cell_col_q <= '0;
						st_q <= ratio_mid ? ST_DIVS : ST_PIX;
					end
				end
				ST_DIVS: begin
					dst_h_q <= dst_h_prod[bais_pkg::SCALE_LOG +: YW];
					dst_w_q <= dst_w_prod[bais_pkg::SCALE_LOG +: XW] + 1'b1;
					if (done_b) begin
						sq_q <= quo_b[RW-1:0];
						sr_q <= rem_b[RW-1:0];
						st_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					if (!(ratio_q < RW'(bais_pkg::SCALE_ONE))) begin
						ored_q <= red_q;
						ogrn_q <= grn_q;
						oblu_q <= blu_q;
						ocol_q <= OCW'(sx_q);
						orow_q <= OCW'(sy_q);
						olast_q <= 1'b1;
						more_q <= 1'b0;
						st_q <= ST_OUT;
					end else if (!fin) begin
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					sums_q <= sums_new;
					area_q <= DEN_W'(XW'(to_q - from_q) * YW'(bb_q - y0_q));
					oc_q <= OCW'(cell_col_q);
					ecol_q <= c_next;
					empty_q <= empty;
					rowend_q <= row_end;
					if (hit) begin
						cell_col_q <= c_next;
						from_q <= to_q;
						to_q <= col_qn;
						to_r_q <= col_rn;
					end
					if (emit) begin
						st_q <= ST_AREA;
					end else if (empty) begin
						ored_q <= '0;
						ogrn_q <= '0;
						oblu_q <= '0;
						ocol_q <= OCW'(c_next);
						orow_q <= OCW'(band_row_q);
						olast_q <= 1'b1;
						more_q <= 1'b0;
						st_q <= ST_OUT;
					end
				end
				ST_AREA: begin
					st_q <= ST_DIVM;
				end
				ST_DIVM: begin
					if (done_r) begin
						ored_q <= quo_r[PW-1:0];
						ogrn_q <= quo_g[PW-1:0];
						oblu_q <= quo_b[PW-1:0];
						ocol_q <= oc_q;
						orow_q <= OCW'(band_row_q);
						olast_q <= !empty_q;
						more_q <= empty_q;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready && more_q) begin
						ored_q <= '0;
						ogrn_q <= '0;
						oblu_q <= '0;
						ocol_q <= OCW'(ecol_q);
						olast_q <= 1'b1;
						more_q <= 1'b0;
					end
				end
				default: st_q <= ST_CLR;
			endcase

			// Close out the pixel: band and raster position advance.
			if (fin) begin
				st_q <= ST_IDLE;
				rowend_q <= 1'b0;
				if (rowend_q && st_q != ST_PIX) begin
					band_row_q <= band_row_q + 1'b1;
					y0_q <= bb_q;
					bb_q <= row_qn;
					bb_r_q <= row_rn;
				end
				if ((EW'(sx_q) + 1'b1) >= EW'(fw_q)) begin
					sx_q <= '0;
					cell_col_q <= '0;
					from_q <= '0;
					to_q <= col_init;
					to_r_q <= sr_q;
					if ((EW'(sy_q) + 1'b1) >= EW'(fh_q)) begin
						sy_q <= '0;
					end else begin
						sy_q <= sy_q + 1'b1;
					end
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end

			// Frame start: first band and first column edges.
			if (st_q == ST_DIVS && done_b) begin
				from_q <= '0;
				to_q <= (EW'(quo_b[RW-1:0]) > EW'(fw_q)) ? EW'(fw_q) : EW'(quo_b[RW-1:0]);
				to_r_q <= rem_b[RW-1:0];
				y0_q <= '0;
				bb_q <= (EW'(quo_b[RW-1:0]) > EW'(fh_q)) ? EW'(fh_q) : EW'(quo_b[RW-1:0]);
				bb_r_q <= rem_b[RW-1:0];
			end
		end
	end

	logic unused_rem;
	assign unused_rem = ^{rem_r, rem_g, done_g, row_init};

`ifndef SYNTHESIS
	// A ratio of zero produces no output rows, so no result may appear.
	a_no_out_zero_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ratio_q != '0)
		else $error("result with zero shrink ratio");

	// One pixel at a time: no input is taken while a result waits.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while result pending");

	// The column walk never passes the extra edge column.
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> cell_col_q <= dst_w_q)
		else $error("cell column beyond output width");

	// A saturated ratio never exceeds one.
	a_ratio_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_q <= RW'(bais_pkg::SCALE_ONE))
		else $error("shrink ratio above one");
`endif

endmodule

`default_nettype wire
